[hdl/udec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udec_pkg: shared types, constants and helpers for the UTF-8 stream decoder
// Field widths, the character limit ceiling and the decode helpers.
// ----------------------------------------------------------------------------
package udec_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned CpW         = 21;
  localparam int unsigned CountW      = 13;
  localparam int unsigned OutDataW    = 40;   // code_point + char_count, byte padded
  localparam int unsigned ResCntW     = 3;    // up to four results per byte

  localparam int unsigned MaxCharsLimit = 4096;
  localparam logic [CountW-1:0] MaxCharsReset = 13'd1024;
  localparam logic [CountW-1:0] LimitCeil     = CountW'(MaxCharsLimit);

  localparam logic [CpW-1:0] QMark = 21'd63;  // '?'

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic              is_end;
    logic [CountW-1:0] char_count;
  } res_t;

  // Total sequence length implied by a held lead byte
  function automatic logic [2:0] seq_len(input logic [ByteW-1:0] lead);
    logic [2:0] len;
    if (lead[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (lead[7:4] == 4'b1110) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Assemble the code point from the held bytes and the final continuation
  function automatic logic [CpW-1:0] decode_cp(input logic [ByteW-1:0] lead,
                                               input logic [ByteW-1:0] c0,
                                               input logic [ByteW-1:0] c1,
                                               input logic [ByteW-1:0] last);
    logic [2:0]     len;
    logic [CpW-1:0] cp;
    len = seq_len(lead);
    if (len == 3'd2) begin
      cp = {10'd0, lead[4:0], last[5:0]};
    end else if (len == 3'd3) begin
      cp = {5'd0, lead[3:0], c0[5:0], last[5:0]};
    end else begin
      cp = {lead[2:0], c0[5:0], c1[5:0], last[5:0]};
    end
    return cp;
  endfunction

endpackage
`default_nettype wire

[hdl/utf8_stream_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: streaming UTF-8 to code point decoder
// Decodes a zero-terminated byte stream into code points with a per-string
// character limit and an end marker carrying the count.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one raw byte per word in s_axis_tdata. A zero byte ends the
//   string and produces an end marker (m_axis_tuser high) whose char_count
//   holds the code points emitted for that string.
//   Master stream: one result per word; m_axis_tlast marks the final result
//   caused by an input byte. Malformed bytes come out as '?'.
//   cfg_we_i/cfg_wdata_i set max_chars (capped at 4096); write only while idle.
// Pipeline: a byte taken into the input register is decoded from there, and its
//   results are presented from the result register.
// Throughput: one byte per cycle while m_axis_tready is high and every byte yields
//   at most one result. A byte that yields several results (up to four: flushed
//   '?' plus the tail) keeps the result register until all are taken; the input
//   register takes one more byte meanwhile, then s_axis_tready drops.
// Stall: when m_axis_tready is low the result word holds; the input register
//   fills and backpressure reaches the slave side.
// Reset: all string state clears, nothing is held, max_chars returns to 1024.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: max_chars
  input  logic                              cfg_we_i,
  input  logic [udec_pkg::CountW-1:0]       cfg_wdata_i,
  // byte stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [udec_pkg::ByteW-1:0]        s_axis_tdata,   // [7:0] in_byte
  // code point stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [udec_pkg::OutDataW-1:0]     m_axis_tdata,   // [20:0] code_point,
                                                            // [33:21] char_count,
                                                            // [39:34] zero
  output logic                              m_axis_tuser,   // [0] is_end
  output logic                              m_axis_tlast    // last_in_run
);

  import udec_pkg::*;

  // configuration
  logic [CountW-1:0] max_chars_q;

  // input register
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;

  // per-string state
  logic [ByteW-1:0]  lead_q, lead_d;
  logic [ByteW-1:0]  cont0_q, cont0_d;
  logic [ByteW-1:0]  cont1_q, cont1_d;
  logic [1:0]        held_q, held_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              lr_q, lr_d;

  // result register
  logic [ResCntW-1:0] left_q, left_d;
  res_t               tail_q, tail_d;

  // decode signals
  logic [CountW-1:0]  lim;
  logic               blocked0;
  logic [CountW-1:0]  room;
  logic               room_le_held;
  logic [1:0]         flush_n;
  logic               is_cont;
  logic               is_lead;
  logic [2:0]         need_len;
  logic [CpW-1:0]     seq_cp;
  logic               advance;
  logic               out_take;
  logic               tail_hit;
  logic [ResCntW-1:0] emits;

  // Effective limit and room left in this string
  assign lim          = (max_chars_q > LimitCeil) ? LimitCeil : max_chars_q;
  assign blocked0     = lr_q || (cnt_q >= lim);
  assign room         = lim - cnt_q;
  assign room_le_held = room <= {{(CountW-2){1'b0}}, held_q};
  assign flush_n      = blocked0 ? 2'd0 : (room_le_held ? room[1:0] : held_q);
  assign is_cont      = in_byte_q inside {[8'h80:8'hBF]};
  assign is_lead      = in_byte_q inside {[8'hC0:8'hF7]};
  assign need_len     = seq_len(lead_q);
  assign seq_cp       = decode_cp(lead_q, cont0_q, cont1_q, in_byte_q);

  // Handshake: decode when the result register is free or its last word is taken
  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign advance       = in_valid_q && ((left_q == '0) || ((left_q == 3'd1) && m_axis_tready));
  assign s_axis_tready = !in_valid_q || advance;

  // Decode one byte against the held state
  always_comb begin
    lead_d   = lead_q;
    cont0_d  = cont0_q;
    cont1_d  = cont1_q;
    held_d   = held_q;
    cnt_d    = cnt_q;
    lr_d     = lr_q;
    emits    = '0;
    tail_hit = 1'b0;
    tail_d   = '{code_point: QMark, is_end: 1'b0, char_count: '0};

    if (in_byte_q == '0) begin
      // flush held bytes, then the end marker
      emits   = {1'b0, flush_n} + 3'd1;
      tail_d  = '{code_point: '0, is_end: 1'b1,
                  char_count: cnt_q + {{(CountW-2){1'b0}}, flush_n}};
      cnt_d   = '0;
      lr_d    = 1'b0;
      held_d  = '0;
      lead_d  = '0;
      cont0_d = '0;
      cont1_d = '0;
    end else if (blocked0) begin
      // drop the byte and anything held
      lr_d   = 1'b1;
      held_d = '0;
    end else begin
      if ((held_q != '0) && is_cont) begin
        if (({1'b0, held_q} + 3'd1) >= need_len) begin
          tail_d.code_point = seq_cp;
          emits             = 3'd1;
          held_d            = '0;
        end else begin
          if (held_q == 2'd1) begin
            cont0_d = in_byte_q;
          end else begin
            cont1_d = in_byte_q;
          end
          held_d = held_q + 2'd1;
        end
      end else begin
        // flush held bytes as '?', then take the byte afresh
        held_d = '0;
        if (!room_le_held) begin
          if (in_byte_q < 8'h80) begin
            tail_d.code_point = {{(CpW-ByteW){1'b0}}, in_byte_q};
            tail_hit          = 1'b1;
          end else if (is_lead) begin
            lead_d = in_byte_q;
            held_d = 2'd1;
          end else begin
            tail_hit = 1'b1;
          end
        end
        emits = {1'b0, flush_n} + {2'b00, tail_hit};
      end
      cnt_d = cnt_q + {{(CountW-ResCntW){1'b0}}, emits};
      lr_d  = cnt_d >= lim;
    end
  end

  // Count down the words of the current result group
  always_comb begin
    left_d = left_q;
    if (advance) begin
      left_d = emits;
    end else if (out_take) begin
      left_d = left_q - 3'd1;
    end
  end

  // Present '?' until the final word of the group, then the tail
  assign m_axis_tvalid = left_q != '0;
  assign m_axis_tlast  = left_q == 3'd1;
  assign m_axis_tuser  = m_axis_tlast ? tail_q.is_end : 1'b0;
  always_comb begin
    if (m_axis_tlast) begin
      m_axis_tdata = {{(OutDataW-CpW-CountW){1'b0}}, tail_q.char_count, tail_q.code_point};
    end else begin
      m_axis_tdata = {{(OutDataW-CpW-CountW){1'b0}}, {CountW{1'b0}}, QMark};
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= MaxCharsReset;
    end else if (cfg_we_i) begin
      max_chars_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // String state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= '0;
      cont0_q <= '0;
      cont1_q <= '0;
      held_q  <= '0;
      cnt_q   <= '0;
      lr_q    <= 1'b0;
      left_q  <= '0;
    end else begin
      left_q <= left_d;
      if (advance) begin
        lead_q  <= lead_d;
        cont0_q <= cont0_d;
        cont1_q <= cont1_d;
        held_q  <= held_d;
        cnt_q   <= cnt_d;
        lr_q    <= lr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tail_q <= tail_d;
    end
  end

endmodule
`default_nettype wire

[sim/tb_utf8_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit: self-checking bench for the UTF-8 stream decoder
// Feeds zero-terminated byte strings into the slave stream, predicts every
// code point, '?' and end marker in a scoreboard, and checks each master word
// under changing flow control and character limits.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_unit;

  localparam int unsigned QuietLimit = 5000;  // cycles without any accepted word
  localparam int unsigned HoldCycles = 300;   // long sink hold-off
  localparam int unsigned PhaseBytes = 28;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned MaxReports = 10;

  typedef enum int {FlowFull, FlowSrcIdle, FlowSnkStall, FlowBoth} flow_e;

  typedef struct {
    logic [udec_pkg::CpW-1:0]    code_point;
    logic                        is_end;
    logic [udec_pkg::CountW-1:0] char_count;
    logic                        last_in_run;
  } cp_word_t;

  // Decoder prediction and result matching
  class cp_scoreboard;
    logic [udec_pkg::CountW-1:0] max_chars;
    logic [7:0]                  lead;
    logic [7:0]                  cont [2];
    int unsigned                 held;       // bytes held, lead included
    logic [udec_pkg::CountW-1:0] emitted;
    bit                          limit_hit;
    cp_word_t                    expected_q[$];
    cp_word_t                    step_q[$];
    int unsigned                 bytes_seen;
    int unsigned                 words_seen;
    int unsigned                 ends_seen;
    int unsigned                 mismatches;

    function new();
      max_chars  = udec_pkg::MaxCharsReset;
      lead       = '0;
      cont[0]    = '0;
      cont[1]    = '0;
      held       = 0;
      emitted    = '0;
      limit_hit  = 1'b0;
      bytes_seen = 0;
      words_seen = 0;
      ends_seen  = 0;
      mismatches = 0;
    endfunction

    function void set_max_chars(input logic [udec_pkg::CountW-1:0] v);
      max_chars = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Register value clipped to the hardware ceiling
    function int unsigned char_cap();
      int unsigned lim;
      lim = max_chars;
      if (lim > udec_pkg::MaxCharsLimit) lim = udec_pkg::MaxCharsLimit;
      return lim;
    endfunction

    function bit is_blocked();
      return limit_hit || (emitted >= char_cap());
    endfunction

    function bit is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
    endfunction

    function bit is_lead(input logic [7:0] b);
      return (b[7:5] == 3'b110) || (b[7:4] == 4'b1110) || (b[7:3] == 5'b11110);
    endfunction

    function int unsigned seq_bytes(input logic [7:0] b);
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      return 4;
    endfunction

    // Queue one code point unless the limit swallows it
    function void put_char(input logic [udec_pkg::CpW-1:0] cp);
      cp_word_t w;
      if (is_blocked()) begin
        limit_hit = 1'b1;
        return;
      end
      w.code_point  = cp;
      w.is_end      = 1'b0;
      w.char_count  = '0;
      w.last_in_run = 1'b0;
      step_q.push_back(w);
      emitted = emitted + 1'b1;
      if (emitted >= char_cap()) limit_hit = 1'b1;
    endfunction

    // Turn a pending sequence into one '?' per held byte
    function void flush_held();
      int unsigned i;
      if (held > 0) begin
        put_char(udec_pkg::QMark);
        for (i = 1; i < held && i < 3; i++) put_char(udec_pkg::QMark);
      end
      held = 0;
    endfunction

    function void start_byte(input logic [7:0] b);
      if (b < 8'h80) begin
        put_char({13'd0, b});
      end else if (is_lead(b)) begin
        if (is_blocked()) begin
          limit_hit = 1'b1;
        end else begin
          lead = b;
          held = 1;
        end
      end else begin
        put_char(udec_pkg::QMark);
      end
    endfunction

    function logic [udec_pkg::CpW-1:0] join_cp(input logic [7:0] tail);
      logic [udec_pkg::CpW-1:0] cp;
      case (seq_bytes(lead))
        2: cp = {10'd0, lead[4:0], tail[5:0]};
        3: cp = {5'd0, lead[3:0], cont[0][5:0], tail[5:0]};
        default: cp = {lead[2:0], cont[0][5:0], cont[1][5:0], tail[5:0]};
      endcase
      return cp;
    endfunction

    // Predict the words caused by one accepted byte
    function void note_byte(input logic [7:0] b);
      cp_word_t w;
      bytes_seen++;
      step_q.delete();
      if (b == 8'h00) begin
        flush_held();
        w.code_point  = '0;
        w.is_end      = 1'b1;
        w.char_count  = emitted;
        w.last_in_run = 1'b0;
        step_q.push_back(w);
        emitted   = '0;
        limit_hit = 1'b0;
        held      = 0;
        lead      = '0;
        cont[0]   = '0;
        cont[1]   = '0;
      end else if (is_blocked()) begin
        limit_hit = 1'b1;
        held      = 0;
      end else if (held > 0) begin
        if (is_cont(b)) begin
          if (held + 1 >= seq_bytes(lead)) begin
            held = 0;
            put_char(join_cp(b));
          end else begin
            cont[(held - 1) % 2] = b;
            held++;
          end
        end else begin
          flush_held();
          start_byte(b);
        end
      end else begin
        start_byte(b);
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last_in_run = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    // Match one master word against the oldest prediction
    function void check_word(input cp_word_t got);
      cp_word_t want;
      words_seen++;
      if (got.is_end) ends_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("ERROR: word %0d with nothing expected: cp=%h end=%b count=%0d last=%b",
                   words_seen, got.code_point, got.is_end, got.char_count, got.last_in_run);
        return;
      end
      want = expected_q.pop_front();
      if (got.code_point !== want.code_point || got.is_end !== want.is_end ||
          got.char_count !== want.char_count || got.last_in_run !== want.last_in_run) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display(
            "ERROR: word %0d exp cp=%h end=%b cnt=%0d last=%b, got cp=%h end=%b cnt=%0d last=%b",
            words_seen, want.code_point, want.is_end, want.char_count,
            want.last_in_run, got.code_point, got.is_end, got.char_count,
            got.last_in_run);
      end
    endfunction
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [udec_pkg::CountW-1:0]   cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [udec_pkg::ByteW-1:0]    s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [udec_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;

  cp_scoreboard sb = new();
  flow_e        flow = FlowFull;
  int unsigned  hold_left = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  limit_writes = 0;

  utf8_stream_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit src_idle(input flow_e f);
    if (f == FlowSrcIdle) return $urandom_range(99) < 86;
    if (f == FlowBoth) return $urandom_range(99) < 11;
    return 1'b0;
  endfunction

  function automatic bit snk_stall(input flow_e f);
    if (f == FlowSnkStall) return $urandom_range(99) < 86;
    if (f == FlowBoth) return $urandom_range(99) < 11;
    return 1'b0;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic logic [7:0] lead_byte(input int unsigned n);
    if (n == 2) return 8'hC0 | 8'($urandom_range(31));
    if (n == 3) return 8'hE0 | 8'($urandom_range(15));
    return 8'hF0 | 8'($urandom_range(7));
  endfunction

  // Sink: stall at random or hold off, check every accepted word
  initial begin : sink
    cp_word_t got;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !snk_stall(flow);
      end
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.code_point  = m_axis_tdata[20:0];
        got.char_count  = m_axis_tdata[33:21];
        got.is_end      = m_axis_tuser;
        got.last_in_run = m_axis_tlast;
        sb.check_word(got);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("ERROR: no word moved for %0d cycles, %0d still expected",
               quiet_cycles, sb.pending());
      $display("tb_utf8_stream_decoder_unit failed");
      $finish;
    end
  end

  // Offer one byte, hold it until taken; call and return at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (src_idle(flow)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  // Drain, let in-flight bytes settle, then write max_chars
  task automatic write_max_chars(input logic [udec_pkg::CountW-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_max_chars(v);
    limit_writes++;
  endtask

  task automatic send_good_char();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(1, 4);
    if (n == 1) begin
      send_byte(8'($urandom_range(1, 127)));
    end else begin
      send_byte(lead_byte(n));
      for (i = 1; i < n; i++) send_byte(cont_byte());
    end
  endtask

  // Lead followed by too few continuations; the next byte breaks it
  task automatic send_short_seq();
    int unsigned n;
    int unsigned k;
    int unsigned i;
    n = $urandom_range(2, 4);
    k = $urandom_range(0, n - 2);
    send_byte(lead_byte(n));
    for (i = 0; i < k; i++) send_byte(cont_byte());
  endtask

  // Mostly well-formed text with terminators, plus malformed noise
  task automatic run_phase(input int unsigned p);
    int unsigned first;
    int unsigned roll;
    flow  = flow_e'(p % 4);
    first = sb.bytes_seen;
    while (sb.bytes_seen - first < PhaseBytes) begin
      roll = $urandom_range(99);
      if (roll < 8) send_byte(8'h00);
      else if (roll < 72) send_good_char();
      else if (roll < 82) send_short_seq();
      else if (roll < 88) send_byte(cont_byte());
      else if (roll < 92) send_byte(8'hF8 | 8'($urandom_range(7)));
      else send_byte(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(1)) send_byte(8'h00);
  endtask

  initial begin : stim
    logic [7:0]                  basics [23];
    logic [udec_pkg::CountW-1:0] limits [NumPhases];
    int unsigned                 p;

    // ASCII ends, 2/3/4-byte extremes, bare continuation, bad leads,
    // broken sequence, zero byte while holding three bytes
    basics = '{8'h01, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
               8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hF8, 8'hFF, 8'hE0, 8'h80,
               8'h41, 8'hF0, 8'h80, 8'h80, 8'h00};
    limits = '{13'd0, 13'd1, 13'd8191, 13'd2, 13'd4096, 13'd5, 13'd3, 13'd1024,
               13'd1, 13'd7};

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (basics[i]) send_byte(basics[i]);

    // lower the limit below the count already reached mid-string
    send_byte(8'h41);
    send_byte(8'h42);
    write_max_chars(13'd1);
    send_byte(8'h43);
    send_byte(8'h00);

    for (p = 0; p < NumPhases; p++) begin
      write_max_chars(limits[p]);
      // fill the decoder against a stopped sink
      if (p == 4) hold_left = HoldCycles;
      run_phase(p);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    $display("run covered %0d bytes in, %0d words out, %0d end markers, %0d limit writes",
             sb.bytes_seen, sb.words_seen, sb.ends_seen, limit_writes);
    $display("flow: free, source idle, sink stall, both; one %0d-cycle sink hold; %0d mismatches",
             HoldCycles, sb.mismatches);
    if (sb.pending() != 0) $display("ERROR: %0d expected words never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_utf8_stream_decoder_unit passed");
    end else begin
      $display("tb_utf8_stream_decoder_unit failed");
    end
    $finish;
  end

endmodule
